/* rtl/pfn_pkg.sv */
// ----------------------------------------------------------------------------
// pfn_pkg
// Shared constants, types and helper functions for the fractal noise core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfn_pkg;

   localparam int MaxOctaves = 8;

   // pipeline: scale multiply, five lane stages, sum, normalize multiply, output
   localparam int PipeDepth = 9;

   // bits of the scaled coordinate that any octave looks at
   localparam int ScaleLsb  = 25 - MaxOctaves;
   localparam int ScaleW    = 48 - ScaleLsb;
   localparam int CellBase  = 40 - ScaleLsb;
   localparam int FracBase  = 24 - ScaleLsb;

   localparam int NoiseW    = 20;
   localparam int SumW      = NoiseW + MaxOctaves;
   localparam int RecipW    = 17;
   localparam int ProdW     = SumW + RecipW + 1;
   localparam int OctW      = $clog2(MaxOctaves + 1);

   localparam int CsrIndexW = 4;
   localparam int CsrDataW  = 32;
   localparam logic [CsrIndexW-1:0] CsrBaseFreq    = CsrIndexW'(0);
   localparam logic [CsrIndexW-1:0] CsrOctaveCount = CsrIndexW'(1);

   localparam logic [31:0] BaseFreqReset    = 32'h0100_0000;
   localparam logic [3:0]  OctaveCountReset = 4'd1;

   typedef logic signed [NoiseW-1:0] noise_type;

   typedef struct packed {
      logic advance;
   } pipe_ctrl_type;

   localparam logic [7:0] PermRom [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
      8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
      8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
      8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
      8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
      8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
      8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
      8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
      8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
      8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
      8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
      8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
      8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
      8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
      8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
      8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
      8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
      8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
      8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
      8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
      8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
      8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
      8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
      8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
   };

   function automatic logic [7:0] perm(input logic [7:0] idx);
      return PermRom[idx];
   endfunction

   // floor(2^(n+15) / (2^n - 1))
   function automatic logic [RecipW-1:0] recip(input logic [OctW-1:0] n);
      logic [RecipW-1:0] r;
      unique case (5'(n))
         5'd1:    r = 17'd65536;
         5'd2:    r = 17'd43690;
         5'd3:    r = 17'd37449;
         5'd4:    r = 17'd34952;
         5'd5:    r = 17'd33825;
         5'd6:    r = 17'd33288;
         5'd7:    r = 17'd33026;
         5'd8:    r = 17'd32896;
         5'd9:    r = 17'd32832;
         5'd10:   r = 17'd32800;
         5'd11:   r = 17'd32784;
         5'd12:   r = 17'd32776;
         5'd13:   r = 17'd32772;
         5'd14:   r = 17'd32770;
         5'd15:   r = 17'd32769;
         5'd16:   r = 17'd32768;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

   // a + floor((b - a) * t / 2^16), result stays between a and b while t is at most 2^16
   function automatic noise_type lerp(input noise_type a, input noise_type b,
                                      input logic [16:0] t);
      logic signed [NoiseW:0]    diff;
      logic signed [NoiseW+18:0] prod;
      diff = $signed({b[NoiseW-1], b}) - $signed({a[NoiseW-1], a});
      prod = diff * $signed({1'b0, t});
      return a + prod[NoiseW+15:16];
   endfunction

endpackage

`default_nettype wire

/* rtl/pfn_octave.sv */
// ----------------------------------------------------------------------------
// pfn_octave
// One octave of 2D gradient noise as a five stage pipeline: square and hash,
// cube and fade polynomial, fade and gradients, x blends, z blend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfn_octave (
   input  wire logic                  clock,
   input  wire pfn_pkg::pipe_ctrl_type ctrl,
   input  wire logic [7:0]            cell_x,
   input  wire logic [7:0]            cell_z,
   input  wire logic [15:0]           frac_x,
   input  wire logic [15:0]           frac_z,
   output pfn_pkg::noise_type         noise
);

   function automatic pfn_pkg::noise_type grad(input logic [7:0] hash,
                                               input logic signed [16:0] dx,
                                               input logic signed [16:0] dz);
      logic signed [19:0] u;
      logic signed [19:0] v;
      logic signed [19:0] su;
      logic signed [19:0] sv;
      u  = hash[2] ? 20'(dz) : 20'(dx);
      v  = hash[2] ? 20'(dx) : 20'(dz);
      su = hash[0] ? -u : u;
      sv = hash[1] ? -(v <<< 1) : (v <<< 1);
      return su + sv;
   endfunction

   // stage a
   logic [15:0] tx_a_ff, tz_a_ff;
   logic [31:0] tx2_a_ff, tz2_a_ff;
   logic [7:0]  ha_a_ff, hb_a_ff, zi_a_ff;

   // stage b
   logic [15:0] tx_b_ff, tz_b_ff;
   logic [31:0] tx3_b_ff, tz3_b_ff;
   logic [19:0] qx_b_ff, qz_b_ff;
   logic [7:0]  aa_b_ff, ab_b_ff, ba_b_ff, bb_b_ff;
   logic [47:0] tx3_in, tz3_in;
   logic [36:0] qx_in, qz_in;

   // stage c
   logic [16:0]        fu_c_ff, fv_c_ff;
   pfn_pkg::noise_type gaa_c_ff, gba_c_ff, gab_c_ff, gbb_c_ff;
   logic [51:0]        fu_in, fv_in;

   // stage d
   pfn_pkg::noise_type x1_d_ff, x2_d_ff;
   logic [16:0]        fv_d_ff;

   // stage e
   pfn_pkg::noise_type noise_e_ff;

   always_comb begin
      tx3_in = 48'(tx2_a_ff) * 48'(tx_a_ff);
      tz3_in = 48'(tz2_a_ff) * 48'(tz_a_ff);
      qx_in  = (37'(tx2_a_ff) * 37'd6) + (37'd10 << 32) - ((37'(tx_a_ff) * 37'd15) << 16);
      qz_in  = (37'(tz2_a_ff) * 37'd6) + (37'd10 << 32) - ((37'(tz_a_ff) * 37'd15) << 16);
      fu_in  = 52'(tx3_b_ff) * 52'(qx_b_ff);
      fv_in  = 52'(tz3_b_ff) * 52'(qz_b_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         tx_a_ff  <= frac_x;
         tz_a_ff  <= frac_z;
         tx2_a_ff <= 32'(frac_x) * 32'(frac_x);
         tz2_a_ff <= 32'(frac_z) * 32'(frac_z);
         ha_a_ff  <= pfn_pkg::perm(cell_x);
         hb_a_ff  <= pfn_pkg::perm(cell_x + 8'd1);
         zi_a_ff  <= cell_z;

         tx_b_ff  <= tx_a_ff;
         tz_b_ff  <= tz_a_ff;
         tx3_b_ff <= tx3_in[47:16];
         tz3_b_ff <= tz3_in[47:16];
         qx_b_ff  <= qx_in[35:16];
         qz_b_ff  <= qz_in[35:16];
         aa_b_ff  <= pfn_pkg::perm(ha_a_ff + zi_a_ff);
         ab_b_ff  <= pfn_pkg::perm(ha_a_ff + zi_a_ff + 8'd1);
         ba_b_ff  <= pfn_pkg::perm(hb_a_ff + zi_a_ff);
         bb_b_ff  <= pfn_pkg::perm(hb_a_ff + zi_a_ff + 8'd1);

         fu_c_ff  <= fu_in[48:32];
         fv_c_ff  <= fv_in[48:32];
         // far corner offsets are fraction - 1.0, i.e. the sign bit set
         gaa_c_ff <= grad(aa_b_ff, $signed({1'b0, tx_b_ff}), $signed({1'b0, tz_b_ff}));
         gba_c_ff <= grad(ba_b_ff, $signed({1'b1, tx_b_ff}), $signed({1'b0, tz_b_ff}));
         gab_c_ff <= grad(ab_b_ff, $signed({1'b0, tx_b_ff}), $signed({1'b1, tz_b_ff}));
         gbb_c_ff <= grad(bb_b_ff, $signed({1'b1, tx_b_ff}), $signed({1'b1, tz_b_ff}));

         x1_d_ff  <= pfn_pkg::lerp(gaa_c_ff, gba_c_ff, fu_c_ff);
         x2_d_ff  <= pfn_pkg::lerp(gab_c_ff, gbb_c_ff, fu_c_ff);
         fv_d_ff  <= fv_c_ff;

         noise_e_ff <= pfn_pkg::lerp(x1_d_ff, x2_d_ff, fv_d_ff);
      end
   end

   assign noise = noise_e_ff;

endmodule

`default_nettype wire

/* rtl/pfn_norm.sv */
// ----------------------------------------------------------------------------
// pfn_norm
// Weighted octave sum, reciprocal normalize and saturation to Q2.13,
// three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfn_norm (
   input  wire logic                        clock,
   input  wire pfn_pkg::pipe_ctrl_type      ctrl,
   input  wire logic [pfn_pkg::OctW-1:0]    octaves,
   input  wire pfn_pkg::noise_type          lane_noise [pfn_pkg::MaxOctaves],
   output logic signed [15:0]               noise_value
);

   localparam logic signed [pfn_pkg::ProdW-1:0] SatHi = pfn_pkg::ProdW'(32767);
   localparam logic signed [pfn_pkg::ProdW-1:0] SatLo = pfn_pkg::ProdW'(-32768);

   logic signed [pfn_pkg::SumW-1:0]  acc_in, acc_ff;
   logic signed [pfn_pkg::ProdW-1:0] prod_in, prod_ff, shifted;
   logic signed [15:0]               out_in, out_ff;

   always_comb begin
      acc_in = '0;
      for (int i = 0; i < pfn_pkg::MaxOctaves; i++) begin
         if (pfn_pkg::OctW'(i) < octaves) begin
            acc_in = acc_in +
                     (pfn_pkg::SumW'(lane_noise[i]) <<< (pfn_pkg::MaxOctaves - 1 - i));
         end
      end
      prod_in = acc_ff * $signed({1'b0, pfn_pkg::recip(octaves)});
      shifted = prod_ff >>> (pfn_pkg::MaxOctaves + 18);
      if (shifted > SatHi) begin
         out_in = 16'sd32767;
      end else if (shifted < SatLo) begin
         out_in = -16'sd32768;
      end else begin
         out_in = shifted[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         acc_ff  <= acc_in;
         prod_ff <= prod_in;
         out_ff  <= out_in;
      end
   end

   assign noise_value = out_ff;

endmodule

`default_nettype wire

/* rtl/perlin_fbm_noise_2d_core.sv */
// ----------------------------------------------------------------------------
// perlin_fbm_noise_2d_core: fractal 2D gradient noise, one sample per cycle
// unless stalled; stages: scale multiply, five octave lane stages, sum, normalize,
// saturate; throughput one transfer per cycle while rsp_ready does not stall the pipe,
// all octaves run as parallel lanes; synchronous reset clears valid bits and loads base_frequency 1.0, one octave
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module perlin_fbm_noise_2d_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [31:0]                req_coord_x,
   input  wire logic signed [31:0]                req_coord_z,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [15:0]                     rsp_noise_value,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pfn_pkg::CsrIndexW-1:0]     csr_index,
   input  wire logic [pfn_pkg::CsrDataW-1:0]      csr_data
);

   logic [31:0]                    base_freq_ff;
   logic [3:0]                     oct_count_ff;
   logic [pfn_pkg::OctW-1:0]       octaves;
   logic [pfn_pkg::PipeDepth-1:0]  vld_ff;
   pfn_pkg::pipe_ctrl_type         ctrl;
   logic signed [64:0]             prod_x, prod_z;
   logic [pfn_pkg::ScaleW-1:0]     scale_x_ff, scale_z_ff;
   pfn_pkg::noise_type             lane_noise [pfn_pkg::MaxOctaves];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_freq_ff <= pfn_pkg::BaseFreqReset;
         oct_count_ff <= pfn_pkg::OctaveCountReset;
      end else if (csr_valid) begin
         if (csr_index == pfn_pkg::CsrBaseFreq) begin
            base_freq_ff <= csr_data;
         end else if (csr_index == pfn_pkg::CsrOctaveCount) begin
            oct_count_ff <= csr_data[3:0];
         end
      end
   end

   always_comb begin
      if (oct_count_ff == 4'd0) begin
         octaves = pfn_pkg::OctW'(1);
      end else if (32'(oct_count_ff) > 32'(pfn_pkg::MaxOctaves)) begin
         octaves = pfn_pkg::OctW'(pfn_pkg::MaxOctaves);
      end else begin
         octaves = pfn_pkg::OctW'(oct_count_ff);
      end
   end

   // whole pipe moves together whenever the output slot is free or drains
   assign ctrl.advance = !rsp_valid || rsp_ready;
   assign req_ready    = ctrl.advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctrl.advance) begin
         vld_ff <= {vld_ff[pfn_pkg::PipeDepth-2:0], req_valid};
      end
   end

   assign rsp_valid = vld_ff[pfn_pkg::PipeDepth-1];

   always_comb begin
      prod_x = req_coord_x * $signed({1'b0, base_freq_ff});
      prod_z = req_coord_z * $signed({1'b0, base_freq_ff});
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         scale_x_ff <= prod_x[47:pfn_pkg::ScaleLsb];
         scale_z_ff <= prod_z[47:pfn_pkg::ScaleLsb];
      end
   end

   // octave g sees the scaled coordinate shifted left by g
   for (genvar g = 0; g < pfn_pkg::MaxOctaves; g++) begin : g_lane
      pfn_octave u_octave (
         .clock  (clock),
         .ctrl   (ctrl),
         .cell_x (scale_x_ff[pfn_pkg::CellBase-g +: 8]),
         .cell_z (scale_z_ff[pfn_pkg::CellBase-g +: 8]),
         .frac_x (scale_x_ff[pfn_pkg::FracBase-g +: 16]),
         .frac_z (scale_z_ff[pfn_pkg::FracBase-g +: 16]),
         .noise  (lane_noise[g])
      );
   end

   pfn_norm u_norm (
      .clock       (clock),
      .ctrl        (ctrl),
      .octaves     (octaves),
      .lane_noise  (lane_noise),
      .noise_value (rsp_noise_value)
   );

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: fractal noise core testbench
// Streams coordinate samples through the core under several frequency and
// octave settings, predicts each noise value bit for bit in a local model of
// the fixed-point octave math, and checks every result transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_noise_value;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [pfn_pkg::CsrIndexW-1:0] csr_index = '0;
   logic [pfn_pkg::CsrDataW-1:0]  csr_data = '0;

   perlin_fbm_noise_2d_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_coord_x     (req_coord_x),
      .req_coord_z     (req_coord_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #1 clock = ~clock;

   // local copy of the register file
   logic [31:0] freq_reg = pfn_pkg::BaseFreqReset;
   logic [3:0]  octaves_reg = pfn_pkg::OctaveCountReset;

   logic signed [15:0] noise_queue [$];
   int mismatches = 0;
   int burst_left = 0;
   int hold_request = 0;

   // ------------------------------------------------------------------------
   // noise prediction
   // ------------------------------------------------------------------------
   function automatic longint fade16(longint unsigned t);
      longint unsigned t3, q;
      t3 = (t * t * t) >> 16;
      q = 6 * t * t + (64'd10 << 32) - ((15 * t) << 16);
      return longint'((t3 * (q >> 16)) >> 32);
   endfunction

   function automatic longint mix(longint a, longint b, longint t);
      return a + (((b - a) * t) >>> 16);
   endfunction

   function automatic longint grad(logic [7:0] hash, longint dx, longint dz);
      logic [2:0] h;
      longint u, v;
      h = hash[2:0];
      u = (h < 4) ? dx : dz;
      v = (h < 4) ? dz : dx;
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      return u + 2 * v;
   endfunction

   function automatic longint octave_noise(logic [63:0] px, logic [63:0] pz);
      logic [7:0] xi, zi, ha, hb, aa, ab, ba, bb;
      longint xf, zf, fu, fv, x1, x2;
      xi = px[47:40];
      zi = pz[47:40];
      xf = longint'(px[39:24]);
      zf = longint'(pz[39:24]);
      fu = fade16(xf);
      fv = fade16(zf);
      ha = pfn_pkg::PermRom[xi];
      hb = pfn_pkg::PermRom[8'(xi + 8'd1)];
      aa = pfn_pkg::PermRom[8'(ha + zi)];
      ab = pfn_pkg::PermRom[8'(ha + zi + 8'd1)];
      ba = pfn_pkg::PermRom[8'(hb + zi)];
      bb = pfn_pkg::PermRom[8'(hb + zi + 8'd1)];
      x1 = mix(grad(aa, xf, zf), grad(ba, xf - 65536, zf), fu);
      x2 = mix(grad(ab, xf, zf - 65536), grad(bb, xf - 65536, zf - 65536), fu);
      return mix(x1, x2, fv);
   endfunction

   function automatic logic signed [15:0] fbm_noise(logic [31:0] x, logic [31:0] z);
      int n;
      logic [63:0] bx, bz;
      longint acc, rcp, scaled;
      n = int'(octaves_reg);
      if (n < 1) n = 1;
      if (n > pfn_pkg::MaxOctaves) n = pfn_pkg::MaxOctaves;
      bx = {{32{x[31]}}, x} * {32'd0, freq_reg};
      bz = {{32{z[31]}}, z} * {32'd0, freq_reg};
      acc = 0;
      for (int i = 0; i < n; i++)
         acc += octave_noise(bx << i, bz << i) *
                (longint'(1) << (pfn_pkg::MaxOctaves - 1 - i));
      rcp = (longint'(1) << (n + 15)) / ((longint'(1) << n) - 1);
      scaled = (acc * rcp) >>> (pfn_pkg::MaxOctaves + 18);
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
      return 16'(scaled);
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_sample(logic [31:0] x, logic [31:0] z);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_coord_x <= x;
      req_coord_z <= z;
      do @(posedge clock); while (!req_ready);
      noise_queue = {noise_queue, fbm_noise(x, z)};
   endtask

   // idle the sender until every expected result is back, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (noise_queue.size() != 0) @(posedge clock);
      repeat (pfn_pkg::PipeDepth + 3) @(posedge clock);
   endtask

   task automatic csr_write(logic [pfn_pkg::CsrIndexW-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == pfn_pkg::CsrBaseFreq) freq_reg = value;
      else if (idx == pfn_pkg::CsrOctaveCount) octaves_reg = value[3:0];
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result side: stall pattern and checker
   // ------------------------------------------------------------------------
   int hold_cnt = 0;
   int stall_mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_cnt = hold_request;
         hold_request = 0;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (mode_left % 5 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (noise_queue.size() == 0) begin
            $display("%0t: unexpected transfer, noise_value %0d", $time, rsp_noise_value);
            mismatches++;
         end else begin
            logic signed [15:0] want;
            want = noise_queue.pop_front();
            if (rsp_noise_value !== want) begin
               $display("%0t: noise_value expected %0d actual %0d",
                        $time, want, rsp_noise_value);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_reset_settings();
      send_sample(32'h0, 32'h0);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF);
      send_sample(32'hFFFF_FFFF, 32'h0000_0001);
      send_sample(32'h0000_8000, 32'h0001_4000);
      send_sample(32'h00FF_FFFF, 32'hFF00_0001);
      drain();
   endtask

   task automatic test_register_extremes();
      // zero frequency samples the origin on every octave
      csr_write(pfn_pkg::CsrBaseFreq, 32'h0);
      csr_write(pfn_pkg::CsrOctaveCount, 32'd8);
      send_sample(32'h1234_5678, 32'h8765_4321);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);
      drain();
      csr_write(pfn_pkg::CsrBaseFreq, 32'hFFFF_FFFF);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_sample(32'h8000_0000, 32'h8000_0000);
      send_sample(32'h5555_5555, 32'hAAAA_AAAA);
      drain();
      // zero octaves act as one, above the max act as the max
      csr_write(pfn_pkg::CsrBaseFreq, 32'h0100_0000);
      csr_write(pfn_pkg::CsrOctaveCount, 32'd0);
      send_sample(32'h0003_4000, 32'hFFFE_C000);
      send_sample(32'h0000_7FFF, 32'h0000_8001);
      drain();
      csr_write(pfn_pkg::CsrOctaveCount, 32'd15);
      send_sample(32'h0003_4000, 32'hFFFE_C000);
      send_sample(32'h0000_7FFF, 32'h0000_8001);
      drain();
      csr_write(pfn_pkg::CsrOctaveCount, 32'd9);
      send_sample(32'h0040_1234, 32'h0080_4321);
      drain();
      // out of range index is ignored
      csr_write(pfn_pkg::CsrIndexW'(2), 32'hDEAD_BEEF);
      csr_write(pfn_pkg::CsrIndexW'(15), 32'h0000_0003);
      send_sample(32'h0000_C000, 32'h0002_2000);
      drain();
   endtask

   task automatic test_backpressure();
      csr_write(pfn_pkg::CsrOctaveCount, 32'd4);
      csr_write(pfn_pkg::CsrBaseFreq, 32'h0080_0000);
      hold_request = 80;
      for (int i = 0; i < 40; i++) begin
         burst_left = 1 + (burst_left > 0 ? burst_left : 1);
         send_sample($urandom, $urandom);
      end
      drain();
   endtask

   task automatic test_random_stream();
      logic [31:0] x, z;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 3)
            0: csr_write(pfn_pkg::CsrBaseFreq, $urandom);
            1: csr_write(pfn_pkg::CsrBaseFreq, 32'h0010_0000 << $urandom_range(0, 8));
            default: csr_write(pfn_pkg::CsrBaseFreq, $urandom_range(0, 32'h0400_0000));
         endcase
         csr_write(pfn_pkg::CsrOctaveCount, $urandom_range(0, 15));
         if ($urandom_range(0, 3) == 0)
            csr_write(pfn_pkg::CsrIndexW'($urandom_range(2, 15)), $urandom);
         for (int i = 0; i < 100; i++) begin
            if ($urandom_range(0, 1) == 0) begin
               x = $urandom;
               z = $urandom;
            end else begin
               x = 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
               z = 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
            end
            send_sample(x, z);
         end
         drain();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_register_extremes();
      test_backpressure();
      test_random_stream();
      drain();
      if (mismatches == 0 && noise_queue.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
